### rtl/cbadm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Credit admission package
// Shared codes, request and result types for the credit admission unit.
// ----------------------------------------------------------------------------
package cbadm_pkg;

	// Operation codes as they arrive on the op field.
	localparam logic [2:0] OP_PRODUCE = 3'd0;
	localparam logic [2:0] OP_ACK     = 3'd1;
	localparam logic [2:0] OP_READ    = 3'd2;
	localparam logic [2:0] OP_TICK    = 3'd3;
	localparam logic [2:0] OP_QUERY   = 3'd4;

	// Configuration register indexes.
	localparam logic [1:0] CFG_MAX_PENDING = 2'd0;
	localparam logic [1:0] CFG_STRATEGY    = 2'd1;
	localparam logic [1:0] CFG_SAMPLE_RATE = 2'd2;

	// Full-stream policies.
	localparam logic [1:0] STRAT_BLOCK  = 2'd0;
	localparam logic [1:0] STRAT_DROP   = 2'd1;
	localparam logic [1:0] STRAT_SAMPLE = 2'd2;
	localparam logic [1:0] STRAT_EVICT  = 2'd3;

	// Statistics counter indexes.
	localparam int NUM_STATS = 7;
	localparam logic [2:0] STAT_PRODUCED    = 3'd0;
	localparam logic [2:0] STAT_CONSUMED    = 3'd1;
	localparam logic [2:0] STAT_DROPPED     = 3'd2;
	localparam logic [2:0] STAT_SAMPLED     = 3'd3;
	localparam logic [2:0] STAT_BLOCKS      = 3'd4;
	localparam logic [2:0] STAT_BLOCK_TICKS = 3'd5;
	localparam logic [2:0] STAT_CREDIT      = 3'd6;

	// Reset values of the configuration registers.
	localparam logic [31:0] MAX_PENDING_RST = 32'd64;
	localparam logic [15:0] SAMPLE_RATE_RST = 16'd10;

	// Queue depths.
	localparam int QUEUE_DEPTH = 4;
	localparam int RES_DEPTH   = 4;

	typedef enum logic [2:0] {
		K_PRODUCE,
		K_ACK,
		K_READ,
		K_TICK,
		K_QUERY
	} kind_t;

	typedef enum logic [2:0] {
		ST_ADDED   = 3'd0,
		ST_DROPPED = 3'd1,
		ST_SAMPLED = 3'd2,
		ST_TIMEOUT = 3'd3,
		ST_PARKED  = 3'd4,
		ST_BUSY    = 3'd5,
		ST_DONE    = 3'd6
	} status_t;

	// A classified request as it travels from the front to the back.
	typedef struct packed {
		kind_t       kind;
		logic [31:0] amount;
		logic [15:0] tmo;
		logic [2:0]  sidx;
		logic        sidx_ok;
	} item_t;

	// One result as it waits in the output queue.
	typedef struct packed {
		status_t     status;
		logic [47:0] value;
		logic [31:0] pending;
		logic        last;
	} res_t;

endpackage

### rtl/cbadm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Credit admission front end
// Accepts requests, decodes the operation and hands them to the queue.
// ----------------------------------------------------------------------------
module cbadm_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         op,
	input  logic [31:0]        amount,
	input  logic [15:0]        timeout_ticks,
	input  logic [2:0]         stat_index,
	output logic               push,
	output cbadm_pkg::item_t   push_item,
	input  logic               q_full
);

	logic             valid_s1;
	cbadm_pkg::item_t item_s1;
	cbadm_pkg::item_t dec;
	logic             legal;

	// Decode the operation; unknown codes are discarded here.
	always_comb begin
		dec.amount  = amount;
		dec.tmo     = timeout_ticks;
		dec.sidx    = stat_index;
		dec.sidx_ok = (stat_index != 3'd7);
		legal       = 1'b1;
		unique case (op)
			cbadm_pkg::OP_PRODUCE: dec.kind = cbadm_pkg::K_PRODUCE;
			cbadm_pkg::OP_ACK:     dec.kind = cbadm_pkg::K_ACK;
			cbadm_pkg::OP_READ:    dec.kind = cbadm_pkg::K_READ;
			cbadm_pkg::OP_TICK:    dec.kind = cbadm_pkg::K_TICK;
			cbadm_pkg::OP_QUERY:   dec.kind = cbadm_pkg::K_QUERY;
			default: begin
				dec.kind = cbadm_pkg::K_PRODUCE;
				legal    = 1'b0;
			end
		endcase
	end

	// The stage stalls only when it holds a request the queue cannot take.
	assign in_stall  = valid_s1 && q_full;
	assign push      = valid_s1 && !q_full;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid && legal;
		end
	end

	// Payload register, loaded when the stage is free to move and a request is valid.
	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= dec;
		end
	end

endmodule

### rtl/cbadm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Credit admission request queue
// Short FIFO that decouples the front end from the execution back end.
// ----------------------------------------------------------------------------
module cbadm_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  cbadm_pkg::item_t push_item,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output cbadm_pkg::item_t head
);

	localparam int PTR_BITS = $clog2(cbadm_pkg::QUEUE_DEPTH);
	localparam int CNT_BITS = $clog2(cbadm_pkg::QUEUE_DEPTH + 1);

	cbadm_pkg::item_t      mem [cbadm_pkg::QUEUE_DEPTH];
	logic [PTR_BITS-1:0]   wr_q;
	logic [PTR_BITS-1:0]   rd_q;
	logic [CNT_BITS-1:0]   cnt_q;

	assign full       = (cnt_q == CNT_BITS'(cbadm_pkg::QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem[rd_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PTR_BITS'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PTR_BITS'(1);
			end
			cnt_q <= cnt_q + CNT_BITS'(push) - CNT_BITS'(pop);
		end
	end

	// Storage write.
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_item;
		end
	end

endmodule

### rtl/cbadm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Credit admission back end
// Holds the credit state and statistics, executes one request per cycle while
// the result queue has room for two, and queues its results for the output channel.
// ----------------------------------------------------------------------------
module cbadm_back #(
	parameter int COUNTER_BITS = 48
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [31:0]      cfg_data,
	input  logic             head_valid,
	input  cbadm_pkg::item_t head,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [2:0]       status,
	output logic [47:0]      value,
	output logic [31:0]      pending,
	output logic             last
);

	localparam int RPTR_BITS = $clog2(cbadm_pkg::RES_DEPTH);
	localparam int RCNT_BITS = $clog2(cbadm_pkg::RES_DEPTH + 1);
	localparam logic [COUNTER_BITS-1:0] CTR_ONE = COUNTER_BITS'(1);

	// Configuration registers.
	logic [31:0] max_q;
	logic [1:0]  strat_q;
	logic [15:0] rate_q;

	// Credit state.
	logic [31:0] pend_q;
	logic [15:0] phase_q;
	logic        parked_q;
	logic [15:0] ptmo_q;
	logic [15:0] wait_q;
	logic [COUNTER_BITS-1:0] ctr_q [cbadm_pkg::NUM_STATS];

	// Next-state values for the request at the head of the queue.
	logic [31:0] pend_n;
	logic [15:0] phase_n;
	logic        parked_n;
	logic [15:0] ptmo_n;
	logic [15:0] wait_n;
	logic [COUNTER_BITS-1:0] inc [cbadm_pkg::NUM_STATS];
	cbadm_pkg::res_t r0;
	cbadm_pkg::res_t r1;
	logic [1:0]  nres;

	logic [31:0] rel;
	logic [31:0] ack_pend;
	logic        has_credit;
	logic [15:0] ph_inc;
	logic [15:0] ph_wrap;
	logic [15:0] wait_inc;
	logic [63:0] ctr_wide;

	// Result queue.
	cbadm_pkg::res_t        rmem [cbadm_pkg::RES_DEPTH];
	logic [RPTR_BITS-1:0]   rwr_q;
	logic [RPTR_BITS-1:0]   rrd_q;
	logic [RCNT_BITS-1:0]   rcnt_q;
	logic                   fire;
	logic                   out_pop;

	// A request executes only when room for two results is certain.
	assign fire    = head_valid && (rcnt_q <= RCNT_BITS'(cbadm_pkg::RES_DEPTH - 2));
	assign pop     = fire;
	assign out_pop = out_valid && !out_stall;

	// Execute the head request.
	always_comb begin
		pend_n   = pend_q;
		phase_n  = phase_q;
		parked_n = parked_q;
		ptmo_n   = ptmo_q;
		wait_n   = wait_q;
		for (int i = 0; i < cbadm_pkg::NUM_STATS; i++) begin
			inc[i] = '0;
		end
		r0   = '0;
		r1   = '0;
		nres = 2'd0;

		rel        = (head.amount < pend_q) ? head.amount : pend_q;
		ack_pend   = pend_q - rel;
		has_credit = (pend_q < max_q);
		ph_inc     = phase_q + 16'd1;
		ph_wrap    = (ph_inc >= rate_q) ? 16'd0 : ph_inc;
		wait_inc   = (wait_q != 16'hFFFF) ? wait_q + 16'd1 : wait_q;
		ctr_wide   = head.sidx_ok ? 64'(ctr_q[head.sidx]) : 64'd0;

		unique case (head.kind)
			cbadm_pkg::K_PRODUCE: begin
				nres = 2'd1;
				if (parked_q) begin
					r0.status = cbadm_pkg::ST_BUSY;
				end else if (has_credit) begin
					pend_n = pend_q + 32'd1;
					inc[cbadm_pkg::STAT_PRODUCED] = CTR_ONE;
					r0.status = cbadm_pkg::ST_ADDED;
				end else begin
					unique case (strat_q)
						cbadm_pkg::STRAT_DROP: begin
							inc[cbadm_pkg::STAT_DROPPED] = CTR_ONE;
							r0.status = cbadm_pkg::ST_DROPPED;
						end
						cbadm_pkg::STRAT_SAMPLE: begin
							phase_n = ph_wrap;
							if (ph_wrap != 16'd0) begin
								inc[cbadm_pkg::STAT_SAMPLED] = CTR_ONE;
								r0.status = cbadm_pkg::ST_SAMPLED;
							end else begin
								pend_n = pend_q + 32'd1;
								inc[cbadm_pkg::STAT_PRODUCED] = CTR_ONE;
								r0.status = cbadm_pkg::ST_ADDED;
							end
						end
						cbadm_pkg::STRAT_EVICT: begin
							// The oldest message leaves as the new one enters;
							// an empty count still ends at one.
							if (pend_q == 32'd0) begin
								pend_n = 32'd1;
							end
							inc[cbadm_pkg::STAT_PRODUCED] = CTR_ONE;
							r0.status = cbadm_pkg::ST_ADDED;
						end
						default: begin
							parked_n  = 1'b1;
							ptmo_n    = head.tmo;
							wait_n    = 16'd0;
							r0.status = cbadm_pkg::ST_PARKED;
						end
					endcase
				end
				r0.pending = pend_n;
			end
			cbadm_pkg::K_ACK: begin
				nres       = 2'd1;
				pend_n     = ack_pend;
				inc[cbadm_pkg::STAT_CREDIT] = COUNTER_BITS'(rel);
				r0.status  = cbadm_pkg::ST_DONE;
				r0.value   = 48'(rel);
				r0.pending = ack_pend;
				// Freed credit admits the parked request as a second result.
				if (parked_q && (ack_pend < max_q)) begin
					nres       = 2'd2;
					parked_n   = 1'b0;
					pend_n     = ack_pend + 32'd1;
					inc[cbadm_pkg::STAT_BLOCKS]   = CTR_ONE;
					inc[cbadm_pkg::STAT_PRODUCED] = CTR_ONE;
					r1.status  = cbadm_pkg::ST_ADDED;
					r1.pending = ack_pend + 32'd1;
				end
			end
			cbadm_pkg::K_READ: begin
				nres       = 2'd1;
				inc[cbadm_pkg::STAT_CONSUMED] = COUNTER_BITS'(rel);
				r0.status  = cbadm_pkg::ST_DONE;
				r0.value   = 48'(rel);
				r0.pending = pend_q;
			end
			cbadm_pkg::K_TICK: begin
				if (parked_q) begin
					wait_n = wait_inc;
					inc[cbadm_pkg::STAT_BLOCK_TICKS] = CTR_ONE;
					if (has_credit) begin
						nres       = 2'd1;
						parked_n   = 1'b0;
						pend_n     = pend_q + 32'd1;
						inc[cbadm_pkg::STAT_BLOCKS]   = CTR_ONE;
						inc[cbadm_pkg::STAT_PRODUCED] = CTR_ONE;
						r0.status  = cbadm_pkg::ST_ADDED;
						r0.pending = pend_q + 32'd1;
					end else if ((ptmo_q != 16'd0) && (wait_inc >= ptmo_q)) begin
						nres       = 2'd1;
						parked_n   = 1'b0;
						inc[cbadm_pkg::STAT_BLOCKS] = CTR_ONE;
						r0.status  = cbadm_pkg::ST_TIMEOUT;
						r0.pending = pend_q;
					end
				end
			end
			cbadm_pkg::K_QUERY: begin
				nres       = 2'd1;
				r0.status  = cbadm_pkg::ST_DONE;
				r0.value   = ctr_wide[47:0];
				r0.pending = pend_q;
			end
			default: begin
				nres = 2'd0;
			end
		endcase

		// Mark the final result of the request.
		if (nres == 2'd1) begin
			r0.last = 1'b1;
		end
		if (nres == 2'd2) begin
			r1.last = 1'b1;
		end
	end

	// Configuration and credit state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q    <= cbadm_pkg::MAX_PENDING_RST;
			strat_q  <= cbadm_pkg::STRAT_BLOCK;
			rate_q   <= cbadm_pkg::SAMPLE_RATE_RST;
			pend_q   <= '0;
			phase_q  <= '0;
			parked_q <= 1'b0;
			ptmo_q   <= '0;
			wait_q   <= '0;
			for (int i = 0; i < cbadm_pkg::NUM_STATS; i++) begin
				ctr_q[i] <= '0;
			end
		end else begin
			if (fire) begin
				pend_q   <= pend_n;
				phase_q  <= phase_n;
				parked_q <= parked_n;
				ptmo_q   <= ptmo_n;
				wait_q   <= wait_n;
				for (int i = 0; i < cbadm_pkg::NUM_STATS; i++) begin
					ctr_q[i] <= ctr_q[i] + inc[i];
				end
			end
			if (cfg_we) begin
				unique case (cfg_index)
					cbadm_pkg::CFG_MAX_PENDING: max_q <= cfg_data;
					cbadm_pkg::CFG_STRATEGY:    strat_q <= cfg_data[1:0];
					cbadm_pkg::CFG_SAMPLE_RATE: begin
						// A rate of zero is kept as one; the phase restarts.
						rate_q  <= (cfg_data[15:0] == 16'd0) ? 16'd1 : cfg_data[15:0];
						phase_q <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Result queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rwr_q  <= '0;
			rrd_q  <= '0;
			rcnt_q <= '0;
		end else begin
			if (fire) begin
				rwr_q <= rwr_q + RPTR_BITS'(nres);
			end
			if (out_pop) begin
				rrd_q <= rrd_q + RPTR_BITS'(1);
			end
			rcnt_q <= rcnt_q + (fire ? RCNT_BITS'(nres) : RCNT_BITS'(0))
				- RCNT_BITS'(out_pop);
		end
	end

	// Result storage, up to two entries written per request.
	always_ff @(posedge clk) begin
		if (fire && (nres != 2'd0)) begin
			rmem[rwr_q] <= r0;
		end
		if (fire && (nres == 2'd2)) begin
			rmem[rwr_q + RPTR_BITS'(1)] <= r1;
		end
	end

	assign out_valid = (rcnt_q != '0);
	assign status    = rmem[rrd_q].status;
	assign value     = rmem[rrd_q].value;
	assign pending   = rmem[rrd_q].pending;
	assign last      = rmem[rrd_q].last;

	// The result queue never overfills.
	a_res_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rcnt_q <= RCNT_BITS'(cbadm_pkg::RES_DEPTH))
		else $error("result queue overfilled");

	// A request is parked only by a produce request executed in the cycle before.
	a_park_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(parked_q) |-> $past(fire && (head.kind == cbadm_pkg::K_PRODUCE)))
		else $error("parked without a produce request");

	// The wait counter moves only while a request is parked.
	a_wait_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(!parked_q && $past(!parked_q)) |-> $stable(wait_q))
		else $error("wait counter moved with nothing parked");

	// Two results always fit when a request executes.
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> rcnt_q <= RCNT_BITS'(cbadm_pkg::RES_DEPTH))
		else $error("request executed without room for its results");

endmodule

### rtl/credit_backpressure_admission_unit.sv
`timescale 1ns / 1ps
// Path: an accepted request is held in the front-end register and the request
// queue, executes from the queue head and offers its results from the result
// queue; an ack that admits a parked request queues both results together.
// Throughput: one request per cycle while the result queue has room for two.
// Reset: asynchronous, active low; clears credit state, statistics and queues
// and loads the register defaults (capacity 64, block policy, sample rate 10).
// ----------------------------------------------------------------------------
// Credit backpressure admission unit
// Credit-based admission control for one stream: front end, request queue and
// execution back end with a result queue.
// ----------------------------------------------------------------------------
module credit_backpressure_admission_unit #(
	parameter int COUNTER_BITS = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  op,
	input  logic [31:0] amount,
	input  logic [15:0] timeout_ticks,
	input  logic [2:0]  stat_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [47:0] value,
	output logic [31:0] pending,
	output logic        last
);

	logic             push;
	cbadm_pkg::item_t push_item;
	logic             q_full;
	logic             pop;
	logic             head_valid;
	cbadm_pkg::item_t head;

	// Request intake and decode.
	cbadm_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.op            (op),
		.amount        (amount),
		.timeout_ticks (timeout_ticks),
		.stat_index    (stat_index),
		.push          (push),
		.push_item     (push_item),
		.q_full        (q_full)
	);

	// Decoupling queue.
	cbadm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// Execution and result delivery.
	cbadm_back #(
		.COUNTER_BITS (COUNTER_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.value      (value),
		.pending    (pending),
		.last       (last)
	);

endmodule
